// ----- hw/rtl/lwi_pkg.sv -----
// Package for the loudness weighting interpolator: breakpoint ROM, widths, types.
`timescale 1ns / 1ps
`default_nettype none
package lwi_pkg;

  localparam int BREAKPOINTS = 31;
  localparam int NSEG        = BREAKPOINTS - 1;
  localparam int SEG_W       = (NSEG > 1) ? $clog2(NSEG) : 1;

  localparam int FREQ_W  = 16;
  localparam int MAG_W   = 32;
  localparam int GAIN_W  = 15;
  localparam int K_W     = 40;             // |dG| * reciprocal, per segment
  localparam int PROD_W  = K_W + FREQ_W;
  localparam int P_W     = MAG_W + GAIN_W + 1;
  localparam int RES_W   = P_W - 14;

  localparam logic [FREQ_W-1:0] FREQ_LIMIT = 16'd50000;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 15'd18350;

  localparam int NSTAGE      = 7;          // total pipeline depth
  localparam int GAIN_STAGES = 5;          // stages inside the gain unit

  typedef logic [FREQ_W-1:0] freq_t;
  typedef logic [GAIN_W-1:0] gain_t;
  typedef logic [GAIN_STAGES-1:0] gain_en_t;

  // Breakpoint frequencies in half-hertz units.
  localparam freq_t FREQ_TAB [BREAKPOINTS] = '{
    16'd0, 16'd40, 16'd50, 16'd63, 16'd80, 16'd100, 16'd126, 16'd160, 16'd200,
    16'd250, 16'd320, 16'd400, 16'd500, 16'd630, 16'd800, 16'd1000, 16'd1260,
    16'd1600, 16'd2000, 16'd2500, 16'd3200, 16'd4000, 16'd5000, 16'd6300,
    16'd8000, 16'd10000, 16'd12600, 16'd16000, 16'd20000, 16'd25000, 16'd50000
  };

  // Breakpoint gains, Q1.14.
  localparam gain_t GAIN_TAB [BREAKPOINTS] = '{
    15'd0, 15'd6554, 15'd6881, 15'd7373, 15'd7864, 15'd8356, 15'd8847,
    15'd9503, 15'd10158, 15'd10813, 15'd11469, 15'd12124, 15'd12943,
    15'd13763, 15'd14418, 15'd15073, 15'd15729, 15'd16220, 15'd16220,
    15'd15565, 15'd15401, 15'd16548, 15'd17859, 15'd18350, 15'd17859,
    15'd16220, 15'd14254, 15'd12616, 15'd11960, 15'd12616, 15'd0
  };

endpackage
`default_nettype wire

// ----- hw/rtl/lwi_gain.sv -----
// Gain unit: segment search, reciprocal interpolation, five register stages.
`timescale 1ns / 1ps
`default_nettype none
module lwi_gain (
  input  wire logic             clk,
  input  wire lwi_pkg::gain_en_t stg_en,
  input  wire lwi_pkg::freq_t    freq,
  output lwi_pkg::gain_t         gain
);
  import lwi_pkg::*;

  // Per-segment constants, folded at elaboration.
  logic [K_W-1:0] seg_k   [NSEG];
  logic           seg_neg [NSEG];

  for (genvar i = 0; i < NSEG; i++) begin : g_seg
    localparam longint unsigned W  = longint'(FREQ_TAB[i+1]) - longint'(FREQ_TAB[i]);
    localparam longint unsigned R  = ((64'd1 << 32) + W / 2) / W;
    localparam int              D  = int'(GAIN_TAB[i+1]) - int'(GAIN_TAB[i]);
    localparam longint unsigned AD = (D < 0) ? longint'(-D) : longint'(D);
    localparam longint unsigned K  = AD * R;
    assign seg_k[i]   = K[K_W-1:0];
    assign seg_neg[i] = (D < 0);
  end

  // stage 1: breakpoint compares
  logic [NSEG-1:0] thermo_r, thermo_nxt;
  freq_t           f1_r;
  logic            inr1_r, inr1_nxt;

  always_comb begin
    for (int i = 0; i < NSEG; i++) begin
      thermo_nxt[i] = (freq >= FREQ_TAB[i]);
    end
    inr1_nxt = (freq != '0) && (freq < FREQ_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      thermo_r <= thermo_nxt;
      f1_r     <= freq;
      inr1_r   <= inr1_nxt;
    end
  end

  // stage 2: segment index, highest breakpoint not above f
  logic [SEG_W-1:0] idx_r, idx_nxt;
  freq_t            f2_r;
  logic             inr2_r;

  always_comb begin
    idx_nxt = '0;
    for (int i = 1; i < NSEG; i++) begin
      if (thermo_r[i]) idx_nxt = SEG_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      idx_r  <= idx_nxt;
      f2_r   <= f1_r;
      inr2_r <= inr1_r;
    end
  end

  // stage 3: table lookup and offset into segment
  logic [K_W-1:0] k_r;
  freq_t          d_r, d_nxt;
  gain_t          g3_r;
  logic           neg3_r, inr3_r;

  assign d_nxt = f2_r - FREQ_TAB[idx_r];

  always_ff @(posedge clk) begin
    if (stg_en[2]) begin
      k_r    <= seg_k[idx_r];
      d_r    <= d_nxt;
      g3_r   <= GAIN_TAB[idx_r];
      neg3_r <= seg_neg[idx_r];
      inr3_r <= inr2_r;
    end
  end

  // stage 4: scaled step times offset
  logic [PROD_W-1:0] prod_r, prod_nxt;
  gain_t             g4_r;
  logic              neg4_r, inr4_r;

  assign prod_nxt = PROD_W'(k_r) * PROD_W'(d_r);

  always_ff @(posedge clk) begin
    if (stg_en[3]) begin
      prod_r <= prod_nxt;
      g4_r   <= g3_r;
      neg4_r <= neg3_r;
      inr4_r <= inr3_r;
    end
  end

  // stage 5: round off the Q0.32 scale and apply the step
  logic [PROD_W-1:0] rnd;
  logic [FREQ_W:0]   q;
  logic [FREQ_W:0]   gsum;
  gain_t             gain_r, gain_nxt;

  always_comb begin
    rnd      = prod_r + (PROD_W'(1) << 31);
    q        = rnd[32 +: (FREQ_W + 1)];
    gsum     = neg4_r ? ((FREQ_W + 1)'(g4_r) - q) : ((FREQ_W + 1)'(g4_r) + q);
    gain_nxt = inr4_r ? gsum[GAIN_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (stg_en[4]) begin
      gain_r <= gain_nxt;
    end
  end

  assign gain = gain_r;

endmodule
`default_nettype wire

// ----- hw/rtl/loudness_weighting_interpolator.sv -----
// An accepted item passes through the gain unit stages, the multiply stage and the output register.
// Throughput: one item per cycle while out_stall is low; each stage holds its own valid bit and
// takes a new item whenever it is empty or its successor moves.
// The gain path holds a 40x16 multiply, the output path a 32x15 multiply.
// Reset (rst_n low, synchronous) clears all stage valid bits; data is not reset.
`timescale 1ns / 1ps
`default_nettype none
module loudness_weighting_interpolator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [lwi_pkg::FREQ_W-1:0]    in_freq_half_hz,
  input  wire logic signed [lwi_pkg::MAG_W-1:0] in_magnitude,
  input  wire logic                          in_last_bin,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [lwi_pkg::MAG_W-1:0]   out_weighted_magnitude,
  output logic [lwi_pkg::GAIN_W-1:0]         out_gain_applied,
  output logic                               out_saturated,
  output logic                               out_last_out
);
  import lwi_pkg::*;

  // valid_r[k] is stage k+1; ready[k] lets stage k+1 load.
  logic [NSTAGE-1:0] valid_r;
  logic [NSTAGE:0]   ready;

  always_comb begin
    ready[NSTAGE] = !out_stall;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      ready[k] = !valid_r[k] || ready[k+1];
    end
  end

  assign in_stall  = !ready[0];
  assign out_valid = valid_r[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (ready[0]) valid_r[0] <= in_valid;
      for (int k = 1; k < NSTAGE; k++) begin
        if (ready[k]) valid_r[k] <= valid_r[k-1];
      end
    end
  end

  // gain unit covers stages 1..5
  gain_t gain5;

  lwi_gain u_gain (
    .clk    (clk),
    .stg_en (ready[GAIN_STAGES-1:0]),
    .freq   (in_freq_half_hz),
    .gain   (gain5)
  );

  // magnitude and marker ride along the gain stages
  logic signed [MAG_W-1:0] mag_r  [GAIN_STAGES];
  logic                    last_r [GAIN_STAGES];

  always_ff @(posedge clk) begin
    if (ready[0]) begin
      mag_r[0]  <= in_magnitude;
      last_r[0] <= in_last_bin;
    end
    for (int k = 1; k < GAIN_STAGES; k++) begin
      if (ready[k]) begin
        mag_r[k]  <= mag_r[k-1];
        last_r[k] <= last_r[k-1];
      end
    end
  end

  // stage 6: magnitude times gain
  logic signed [P_W-1:0] p_r, p_nxt;
  gain_t                 gain6_r;
  logic                  last6_r;

  assign p_nxt = P_W'(mag_r[GAIN_STAGES-1]) * $signed({1'b0, gain5});

  always_ff @(posedge clk) begin
    if (ready[GAIN_STAGES]) begin
      p_r     <= p_nxt;
      gain6_r <= gain5;
      last6_r <= last_r[GAIN_STAGES-1];
    end
  end

  // stage 7: round half up, saturate, output register
  logic signed [P_W-1:0]   biased;
  logic signed [RES_W-1:0] res;
  logic signed [MAG_W-1:0] wm_nxt;
  logic                    sat_nxt;

  always_comb begin
    biased = p_r + P_W'(8192);
    res    = RES_W'(biased >>> 14);
    if (res > RES_W'(32'sh7FFF_FFFF)) begin
      wm_nxt  = 32'sh7FFF_FFFF;
      sat_nxt = 1'b1;
    end else if (res < -(RES_W'(33'sh0_8000_0000))) begin
      wm_nxt  = 32'sh8000_0000;
      sat_nxt = 1'b1;
    end else begin
      wm_nxt  = res[MAG_W-1:0];
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ready[NSTAGE-1]) begin
      out_weighted_magnitude <= wm_nxt;
      out_gain_applied       <= gain6_r;
      out_saturated          <= sat_nxt;
      out_last_out           <= last6_r;
    end
  end

  a_zero_gain_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_gain_applied == '0) |-> (out_weighted_magnitude == '0) && !out_saturated)
    else $error("zero gain gave nonzero result");

  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_gain_applied <= GAIN_MAX))
    else $error("gain above table maximum");

  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> valid_r[0])
    else $error("accepted item lost at stage 1");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[NSTAGE-2] && !ready[NSTAGE-1] |=> valid_r[NSTAGE-2])
    else $error("stalled item dropped at stage 6");

endmodule
`default_nettype wire

// ----- test/tb_loudness_weighting_interpolator.sv -----
// Self-checking testbench for loudness_weighting_interpolator: directed and random bins, in-order checking.
`timescale 1ns / 1ps
module tb_loudness_weighting_interpolator;
  import lwi_pkg::*;

  localparam int     RANDOM_BINS = 1900;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     DRAIN_CYCLES = 3 * NSTAGE;
  localparam longint MAG_HI = 64'sd2147483647;
  localparam longint MAG_LO = -MAG_HI - 1;

  typedef struct {
    freq_t              freq;
    logic signed [31:0] mag;
    logic               last;
  } bin_t;

  typedef struct {
    logic signed [31:0] weighted;
    gain_t              gain;
    logic               sat;
    logic               last;
  } weighted_bin_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  freq_t in_freq_half_hz = '0;
  logic signed [MAG_W-1:0] in_magnitude = '0;
  logic in_last_bin = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [MAG_W-1:0] out_weighted_magnitude;
  gain_t out_gain_applied;
  logic out_saturated;
  logic out_last_out;

  bin_t          bins_to_send[$];
  weighted_bin_t expected_weights[$];
  int            bins_total = 0;
  int            bins_taken = 0;
  int            errors = 0;
  int            cycles = 0;
  logic          idle_ok;

  loudness_weighting_interpolator dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_freq_half_hz        (in_freq_half_hz),
    .in_magnitude           (in_magnitude),
    .in_last_bin            (in_last_bin),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_weighted_magnitude (out_weighted_magnitude),
    .out_gain_applied       (out_gain_applied),
    .out_saturated          (out_saturated),
    .out_last_out           (out_last_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // piecewise-linear gain; segment width division done via rounded Q0.32 reciprocal
  function automatic gain_t curve_gain(freq_t f);
    longint unsigned w, d, r, ad, q;
    int delta, g;
    if (f == '0 || f >= FREQ_LIMIT) return '0;
    for (int i = 0; i < BREAKPOINTS - 1; i++) begin
      if (f >= FREQ_TAB[i] && f < FREQ_TAB[i+1]) begin
        w = longint'(FREQ_TAB[i+1]) - longint'(FREQ_TAB[i]);
        d = longint'(f) - longint'(FREQ_TAB[i]);
        r = ((64'd1 << 32) + w / 2) / w;
        delta = int'(GAIN_TAB[i+1]) - int'(GAIN_TAB[i]);
        ad = (delta < 0) ? longint'(-delta) : longint'(delta);
        q = (ad * d * r + (64'd1 << 31)) >> 32;
        g = (delta < 0) ? int'(GAIN_TAB[i]) - int'(q) : int'(GAIN_TAB[i]) + int'(q);
        return gain_t'(g);
      end
    end
    return '0;
  endfunction

  function automatic weighted_bin_t weigh_bin(bin_t b);
    weighted_bin_t res;
    longint prod, scaled;
    res.gain = curve_gain(b.freq);
    prod = longint'(b.mag) * longint'({1'b0, res.gain});
    scaled = (prod + 64'sd8192) >>> 14;  // rounds halves up
    res.sat = 1'b0;
    if (scaled > MAG_HI) begin
      scaled = MAG_HI;
      res.sat = 1'b1;
    end else if (scaled < MAG_LO) begin
      scaled = MAG_LO;
      res.sat = 1'b1;
    end
    res.weighted = scaled[31:0];
    res.last = b.last;
    return res;
  endfunction

  task automatic add_bin(freq_t f, logic signed [31:0] m, logic l);
    bin_t b;
    b.freq = f;
    b.mag = m;
    b.last = l;
    bins_to_send.push_back(b);
    bins_total++;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("cycle %0d: %s mismatch, got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // a long stretch with both sides running flat out
  assign idle_ok = !(cycles >= 1500 && cycles < 2700);

  always @(posedge clk) begin
    bin_t nxt;
    bin_t sent;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        sent.freq = in_freq_half_hz;
        sent.mag = in_magnitude;
        sent.last = in_last_bin;
        expected_weights.push_back(weigh_bin(sent));
        bins_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (bins_to_send.size() != 0 && !(idle_ok && $urandom_range(99) < 31)) begin
          nxt = bins_to_send.pop_front();
          in_valid <= 1'b1;
          in_freq_half_hz <= nxt.freq;
          in_magnitude <= nxt.mag;
          in_last_bin <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    weighted_bin_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_weights.size() == 0) begin
          report_mismatch("unexpected item, weighted_magnitude", out_weighted_magnitude, 0);
        end else begin
          want = expected_weights.pop_front();
          if (out_weighted_magnitude !== want.weighted)
            report_mismatch("weighted_magnitude", out_weighted_magnitude, want.weighted);
          if (out_gain_applied !== want.gain)
            report_mismatch("gain_applied", out_gain_applied, want.gain);
          if (out_saturated !== want.sat)
            report_mismatch("saturated", out_saturated, want.sat);
          if (out_last_out !== want.last)
            report_mismatch("last_out", out_last_out, want.last);
        end
      end
      out_stall <= idle_ok && ($urandom_range(99) < 31);
    end
  end

  initial begin
    int sel, idx;
    freq_t f;
    logic signed [31:0] m;

    // directed: range ends, breakpoints and their neighbors, clipping both ways
    add_bin(16'd0, 32'sh7fffffff, 1'b0);
    add_bin(16'd1, 32'sd1, 1'b0);
    add_bin(16'd39, 32'sh00010000, 1'b0);
    add_bin(16'd40, 32'sh00010000, 1'b0);
    add_bin(16'd41, -32'sh00010000, 1'b0);
    add_bin(16'd63, 32'sd12345, 1'b1);
    add_bin(16'd6300, 32'sh7fffffff, 1'b0);
    add_bin(16'd6300, 32'sh80000000, 1'b0);
    add_bin(16'd6300, -32'sd1, 1'b0);
    add_bin(16'd6299, 32'sh70000000, 1'b0);
    add_bin(16'd2000, 32'sh80000000, 1'b0);
    add_bin(16'd24999, 32'sh7fffffff, 1'b0);
    add_bin(16'd25000, 32'sh80000000, 1'b0);
    add_bin(16'd49999, -32'sd1, 1'b0);
    add_bin(16'd50000, 32'sh7fffffff, 1'b1);
    add_bin(16'd50001, 32'sh80000000, 1'b0);
    add_bin(16'd65535, 32'sh80000000, 1'b0);
    add_bin(16'd32768, 32'sh5555aaaa, 1'b1);
    add_bin(16'd12600, 32'sh00010000, 1'b0);
    add_bin(16'd100, 32'sd0, 1'b0);
    add_bin(16'd1000, 32'sd1, 1'b1);

    for (int n = 0; n < RANDOM_BINS; n++) begin
      sel = $urandom_range(99);
      if (sel < 10) begin
        idx = $urandom_range(BREAKPOINTS - 1);
        f = FREQ_TAB[idx] + freq_t'($urandom_range(2)) - 16'd1;
      end else if (sel < 18) begin
        f = freq_t'($urandom_range(65535, 50000));
      end else if (sel < 20) begin
        f = '0;
      end else if (sel < 50) begin
        f = freq_t'($urandom_range(2600, 1));
      end else begin
        f = freq_t'($urandom_range(49999, 1));
      end
      sel = $urandom_range(99);
      if (sel < 40) begin
        m = $urandom;
      end else if (sel < 60) begin
        m = $signed($urandom_range(32'h3ffff)) - 32'sh20000;
      end else if (sel < 85) begin
        m = 32'sh70000000 + $signed($urandom_range(32'h0fffffff));
        if ($urandom_range(1)) m = -m;
      end else begin
        case ($urandom_range(4))
          0: m = 32'sh7fffffff;
          1: m = 32'sh80000000;
          2: m = 32'sd0;
          3: m = -32'sd1;
          default: m = 32'sd1;
        endcase
      end
      add_bin(f, m, $urandom_range(15) == 0);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (bins_taken != bins_total) @(posedge clk);
    while (expected_weights.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/lwi_pkg.sv
hw/rtl/lwi_gain.sv
hw/rtl/loudness_weighting_interpolator.sv
test/tb_loudness_weighting_interpolator.sv
